>>> rtl/iem_pkg.sv
// Shared types and constants for the I2C EEPROM master.
// Used by the front, queue, back and top-level modules; no dependencies.
package iem_pkg;

  // Default EEPROM size in bytes
  localparam int EEPROM_BYTES_DEF = 8192;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Device address after reset
  localparam logic [6:0] DEV_ADDR_RST = 7'd80;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_PROBE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOACK = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // One classified tick as it travels from front to back
  typedef struct packed {
    req_t        req_type;
    logic        range_err;
    logic [12:0] byte_offset;
    logic [7:0]  write_byte;
    logic [13:0] byte_count;
    logic        sda_sample;
  } in_item_t;

  // One result of a tick
  typedef struct packed {
    logic        scl_drive;
    logic        sda_drive;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        read_last;
    logic        done_res;
    status_t     status;
    logic        busy_res;
  } out_item_t;

endpackage

>>> rtl/iem_front.sv
// Front end of the I2C EEPROM master: unpacks a tick and checks its range.
// Depends on iem_pkg.
module iem_front import iem_pkg::*; #(
  parameter int EEPROM_BYTES = EEPROM_BYTES_DEF
) (
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output in_item_t    item
);

  localparam int LIM_W = $clog2(EEPROM_BYTES + 1);
  localparam int CMP_W = (LIM_W > 15) ? LIM_W : 15;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(EEPROM_BYTES);

  req_t             req;
  logic [13:0]      len;
  logic [CMP_W-1:0] off_ext;
  logic [CMP_W-1:0] end_ext;
  logic             range_err;

  assign req = req_t'(in_tuser);

  // Pick the transfer length for the range check
  always_comb begin
    case (req)
      REQ_READ:  len = in_tdata[34:21];
      REQ_WRITE: len = 14'd1;
      default:   len = 14'd0;
    endcase
  end

  // Flag an access that runs past the end of the device
  assign off_ext   = CMP_W'(in_tdata[12:0]);
  assign end_ext   = off_ext + CMP_W'(len);
  assign range_err = (req != REQ_PROBE) && ((off_ext > LIMIT) || (end_ext > LIMIT));

  // Unpack the fields
  always_comb begin
    item.req_type    = req;
    item.range_err   = range_err;
    item.byte_offset = in_tdata[12:0];
    item.write_byte  = in_tdata[20:13];
    item.byte_count  = in_tdata[34:21];
    item.sda_sample  = in_tdata[35];
  end

endmodule

>>> rtl/iem_queue.sv
// Short queue of classified ticks between front and back.
// Depends on iem_pkg.
module iem_queue import iem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output in_item_t head_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  in_item_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/iem_back.sv
// Back end of the I2C EEPROM master: bus sequencer, one line change per tick,
// and the result register. Depends on iem_pkg.
module iem_back import iem_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       q_valid,
  input  in_item_t   q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  typedef enum logic [4:0] {
    S_IDLE, P_START1, P_STOP1, P_START2, P_ADDR, P_STOP2,
    R_START1, R_ADDRW, R_HI, R_LO, R_STOP1, R_START2, R_ADDRR, R_GET, R_STOP2,
    W_START, W_ADDR, W_HI, W_LO, W_DATA, W_STOP, W_PSTART, W_PADDR, W_PSTOP,
    F_STOP
  } step_t;

  typedef enum logic [1:0] {
    K_START, K_STOP, K_PUT, K_GET
  } kind_t;

  function automatic kind_t kind_of(step_t s);
    case (s)
      P_START1, P_START2, R_START1, R_START2, W_START, W_PSTART: kind_of = K_START;
      P_STOP1, P_STOP2, R_STOP1, R_STOP2, W_STOP, W_PSTOP, F_STOP: kind_of = K_STOP;
      R_GET:   kind_of = K_GET;
      default: kind_of = K_PUT;
    endcase
  endfunction

  function automatic logic [4:0] seg_last(kind_t k);
    case (k)
      K_START: seg_last = 5'd1;
      K_STOP:  seg_last = 5'd2;
      K_PUT:   seg_last = 5'd27;
      default: seg_last = 5'd21;
    endcase
  endfunction

  function automatic logic [7:0] put_byte_of(step_t s, logic [12:0] addr,
                                             logic [7:0] data, logic [6:0] dev);
    case (s)
      R_ADDRR:     put_byte_of = {dev, 1'b1};
      R_HI, W_HI:  put_byte_of = {3'b000, addr[12:8]};
      R_LO, W_LO:  put_byte_of = addr[7:0];
      W_DATA:      put_byte_of = data;
      default:     put_byte_of = {dev, 1'b0};
    endcase
  endfunction

  logic        fire;
  logic [6:0]  dev_addr_r;
  step_t       step_r, step_nxt, step_sel;
  logic [4:0]  seg_r, seg_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [12:0] addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_r, ack_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  kind_t       kind;
  logic [7:0]  pbyte;
  logic        smp;
  logic [8:0]  prod;
  logic [2:0]  bit_n;
  logic [1:0]  bit_r;

  // Take a tick whenever the result register is free or draining
  assign fire          = q_valid && (!out_valid_r || out_ready);
  assign q_pop         = fire;
  assign out_valid_nxt = fire || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

  // One sequencer step for the tick at the head of the queue
  always_comb begin
    step_nxt  = step_r;
    seg_nxt   = seg_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    step_sel  = S_IDLE;
    kind      = K_PUT;
    pbyte     = '0;
    smp       = 1'b0;
    prod      = '0;
    bit_n     = '0;
    bit_r     = '0;
    out_nxt   = '0;
    out_nxt.status = ST_OK;

    // Start a command when idle
    if (step_r == S_IDLE && q_item.req_type != REQ_TICK) begin
      if (q_item.range_err) begin
        out_nxt.done_res = 1'b1;
        out_nxt.status   = ST_RANGE;
      end else begin
        addr_nxt  = q_item.byte_offset;
        data_nxt  = q_item.write_byte;
        rem_nxt   = q_item.byte_count;
        seg_nxt   = '0;
        shift_nxt = '0;
        case (q_item.req_type)
          REQ_READ:  step_nxt = R_START1;
          REQ_WRITE: step_nxt = W_START;
          default:   step_nxt = P_START1;
        endcase
      end
    end

    if (step_nxt != S_IDLE) begin
      kind  = kind_of(step_nxt);
      pbyte = put_byte_of(step_nxt, addr_nxt, data_nxt, dev_addr_r);
      // Make the line change for this tick
      case (kind)
        K_START: begin
          if (seg_nxt == 5'd0) sda_nxt = 1'b0;
          else scl_nxt = 1'b0;
        end
        K_STOP: begin
          if (seg_nxt == 5'd0) sda_nxt = 1'b0;
          else if (seg_nxt == 5'd1) scl_nxt = 1'b1;
          else sda_nxt = 1'b1;
        end
        K_PUT: begin
          // Split the tick into bit number and phase (divide by three)
          prod  = 9'(seg_nxt) * 9'd11;
          bit_n = prod[7:5];
          bit_r = 2'(seg_nxt - 5'({2'b00, bit_n} << 1) - 5'({2'b00, bit_n}));
          if (seg_nxt < 5'd24) begin
            if (bit_r == 2'd0) sda_nxt = pbyte[~bit_n];
            else scl_nxt = (bit_r == 2'd1);
          end else if (seg_nxt == 5'd24) begin
            sda_nxt = 1'b1;
          end else if (seg_nxt == 5'd25) begin
            scl_nxt = 1'b1;
            smp     = 1'b1;
          end else if (seg_nxt == 5'd26) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b0;
          end
        end
        default: begin
          if (seg_nxt == 5'd0) begin
            scl_nxt = 1'b0;
          end else if (seg_nxt == 5'd1) begin
            sda_nxt = 1'b1;
          end else if (seg_nxt < 5'd18) begin
            scl_nxt = !seg_nxt[0];
            smp     = !seg_nxt[0];
          end else if (seg_nxt == 5'd18) begin
            sda_nxt = !(rem_nxt > 14'd1);
          end else if (seg_nxt == 5'd19) begin
            scl_nxt = 1'b1;
          end else if (seg_nxt == 5'd20) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b0;
          end
        end
      endcase

      // Capture the ack or the data bit
      if (smp) begin
        if (kind == K_PUT) ack_nxt = !q_item.sda_sample;
        else shift_nxt = {shift_nxt[6:0], q_item.sda_sample};
      end

      // Advance within the primitive, or move to the next one
      if (seg_nxt != seg_last(kind)) begin
        seg_nxt = seg_nxt + 5'd1;
      end else begin
        seg_nxt  = '0;
        step_sel = step_t'(step_nxt + 5'd1);
        case (step_nxt)
          P_STOP2: begin
            out_nxt.done_res = 1'b1;
            out_nxt.status   = ack_nxt ? ST_OK : ST_NOACK;
            step_sel         = S_IDLE;
          end
          R_ADDRW, W_ADDR: begin
            if (!ack_nxt) step_sel = F_STOP;
          end
          R_ADDRR: begin
            if (rem_nxt == 14'd0) step_sel = R_STOP2;
          end
          R_GET: begin
            out_nxt.read_byte  = shift_nxt;
            out_nxt.read_valid = 1'b1;
            out_nxt.read_last  = (rem_nxt == 14'd1);
            rem_nxt            = rem_nxt - 14'd1;
            shift_nxt          = '0;
            step_sel           = (rem_nxt == 14'd0) ? R_STOP2 : R_GET;
          end
          R_STOP2: begin
            out_nxt.done_res = 1'b1;
            step_sel         = S_IDLE;
          end
          W_PSTOP: begin
            if (ack_nxt) begin
              out_nxt.done_res = 1'b1;
              step_sel         = S_IDLE;
            end else begin
              step_sel = W_PSTART;
            end
          end
          F_STOP: begin
            out_nxt.done_res = 1'b1;
            out_nxt.status   = ST_NOACK;
            step_sel         = S_IDLE;
          end
          default: ;
        endcase
        step_nxt = step_sel;
      end
    end

    out_nxt.scl_drive = scl_nxt;
    out_nxt.sda_drive = sda_nxt;
    out_nxt.busy_res  = (step_nxt != S_IDLE);
  end

  // Hold sequencer state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      step_r      <= S_IDLE;
      seg_r       <= '0;
      shift_r     <= '0;
      rem_r       <= '0;
      addr_r      <= '0;
      data_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dev_addr_r <= cfg_wr_data;
      end
      if (fire) begin
        step_r  <= step_nxt;
        seg_r   <= seg_nxt;
        shift_r <= shift_nxt;
        rem_r   <= rem_nxt;
        addr_r  <= addr_nxt;
        data_r  <= data_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/i2c_eeprom_master_unit.sv
// Top level of the I2C EEPROM master: front, queue and back sequencer.
// Depends on iem_pkg, iem_front, iem_queue and iem_back.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata: offset, wbyte, count, sda
//          |     |                        | tuser: req_type
//  out_    | out | out_tvalid / out_tready| tdata: scl, sda, rbyte, done, status,
//          |     |                        | busy; tuser: read_valid; tlast
//  cfg_    | in  | cfg_wr_en              | cfg_wr_data: device address
//
// One tick is accepted per cycle while the queue has room; its result is registered
// after the queue and the sequencer. The rate is set by the sequencer, which retires
// one tick per cycle unless the result register is stalled. Reset is synchronous;
// no clearing pass is needed. A stall on the result side fills the two-entry queue before in_tready drops.
module i2c_eeprom_master_unit import iem_pkg::*; #(
  parameter int EEPROM_BYTES = EEPROM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [12:0] byte_offset, [20:13] write_byte, [34:21] byte_count,
  // [35] sda_sample, [39:36] zero
  input  logic [39:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] scl_drive, [1] sda_drive, [9:2] read_byte, [10] done_res,
  // [12:11] status, [13] busy_res, [15:14] zero
  output logic [15:0] out_tdata,
  // [0] read_valid
  output logic [0:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  in_item_t  front_item;
  in_item_t  head_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  out_item_t res;

  iem_front #(
    .EEPROM_BYTES(EEPROM_BYTES)
  ) u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .item     (front_item)
  );

  iem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  iem_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_item    (res)
  );

  assign in_tready = !q_full;

  // Pack the result
  assign out_tdata = {2'b00, res.busy_res, res.status, res.done_res,
                      res.read_byte, res.sda_drive, res.scl_drive};
  assign out_tuser = res.read_valid;
  assign out_tlast = res.read_last;

  // A delivered byte is always followed by the closing stop
  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[13])
    else $error("read byte delivered while sequencer idle");

  // A finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> !out_tdata[13])
    else $error("done reported while still busy");

  // The last flag only marks a delivered byte
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("tlast without read byte");

  // The queue fills only behind a stalled result
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("queue full with empty result register");

endmodule

>>> bench/tb_i2c_eeprom_master_unit.sv
// Self-checking bench for i2c_eeprom_master_unit: drives bus ticks with probe, read and
// write commands, predicts every SCL/SDA level and completion, and compares each result.
// Depends on iem_pkg and the RTL of i2c_eeprom_master_unit only.
module tb_i2c_eeprom_master_unit;
  import iem_pkg::*;

  // Sequencer steps of the master, in issue order
  typedef enum logic [4:0] {
    SQ_IDLE, SQ_P_START1, SQ_P_STOP1, SQ_P_START2, SQ_P_ADDR, SQ_P_STOP2,
    SQ_R_START1, SQ_R_ADDRW, SQ_R_HI, SQ_R_LO, SQ_R_STOP1, SQ_R_START2, SQ_R_ADDRR,
    SQ_R_GET, SQ_R_STOP2, SQ_W_START, SQ_W_ADDR, SQ_W_HI, SQ_W_LO, SQ_W_DATA,
    SQ_W_STOP, SQ_W_PSTART, SQ_W_PADDR, SQ_W_PSTOP, SQ_F_STOP
  } seq_step_t;

  typedef enum logic [1:0] {PRIM_START, PRIM_STOP, PRIM_PUT, PRIM_GET} bus_prim_t;

  typedef struct packed {
    req_t        req;
    logic [12:0] offset;
    logic [7:0]  wbyte;
    logic [13:0] count;
    logic        sda;
  } bus_tick_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [12:0] byte_offset, [20:13] write_byte, [34:21] byte_count, [35] sda_sample
  logic [39:0] in_tdata = '0;
  // [1:0] req_type
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] scl, [1] sda, [9:2] read_byte, [10] done, [12:11] status, [13] busy
  logic [15:0] out_tdata;
  // [0] read_valid
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  i2c_eeprom_master_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Master state as predicted by the bench
  logic [6:0]  p_dev;
  seq_step_t   p_step;
  logic [7:0]  p_shift;
  logic [13:0] p_left;
  logic [12:0] p_addr;
  logic [7:0]  p_data;
  logic        p_scl;
  logic        p_sda;
  int          p_tick;
  logic        p_ack;

  bus_tick_t   tick_backlog[$];
  out_item_t   bus_levels_q[$];
  bus_tick_t   drv_tick;
  int          burst_left = 0;
  int          gap_left = 0;

  int n_cmds = 0, n_queued = 0, n_checked = 0, n_bad = 0;
  int n_bytes = 0, n_ok = 0, n_noack = 0, n_range = 0;

  int          hold_asks = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic [31:0] rdy_pat = '1;
  int          pat_age = 0;

  // Advance the predicted master by one bus tick and return its line levels
  function automatic out_item_t step_master(bus_tick_t tk);
    out_item_t  res;
    int         span;
    int         t;
    int         seg_ticks;
    bus_prim_t  prim;
    logic [7:0] tx_byte;
    logic       take;
    seq_step_t  nxt;
    res = '0;
    take = 1'b0;
    // Accept a command only when idle; range errors end on the accept tick
    if (p_step == SQ_IDLE && tk.req != REQ_TICK) begin
      span = (tk.req == REQ_READ) ? int'(tk.count) : (tk.req == REQ_WRITE) ? 1 : 0;
      if (tk.req != REQ_PROBE && int'(tk.offset) + span > EEPROM_BYTES_DEF) begin
        res.done_res = 1'b1;
        res.status = ST_RANGE;
      end else begin
        p_addr = tk.offset;
        p_data = tk.wbyte;
        p_left = tk.count;
        p_tick = 0;
        p_shift = '0;
        p_step = (tk.req == REQ_READ) ? SQ_R_START1 :
                 (tk.req == REQ_WRITE) ? SQ_W_START : SQ_P_START1;
      end
    end
    if (p_step != SQ_IDLE) begin
      case (p_step)
        SQ_P_START1, SQ_P_START2, SQ_R_START1, SQ_R_START2, SQ_W_START, SQ_W_PSTART:
          prim = PRIM_START;
        SQ_P_STOP1, SQ_P_STOP2, SQ_R_STOP1, SQ_R_STOP2, SQ_W_STOP, SQ_W_PSTOP, SQ_F_STOP:
          prim = PRIM_STOP;
        SQ_R_GET: prim = PRIM_GET;
        default:  prim = PRIM_PUT;
      endcase
      case (p_step)
        SQ_R_ADDRR:       tx_byte = {p_dev, 1'b1};
        SQ_R_HI, SQ_W_HI: tx_byte = {3'b000, p_addr[12:8]};
        SQ_R_LO, SQ_W_LO: tx_byte = p_addr[7:0];
        SQ_W_DATA:        tx_byte = p_data;
        default:          tx_byte = {p_dev, 1'b0};
      endcase
      // One line change per tick
      t = p_tick;
      case (prim)
        PRIM_START: begin
          seg_ticks = 2;
          if (t == 0) p_sda = 1'b0;
          else p_scl = 1'b0;
        end
        PRIM_STOP: begin
          seg_ticks = 3;
          if (t == 0) p_sda = 1'b0;
          else if (t == 1) p_scl = 1'b1;
          else p_sda = 1'b1;
        end
        PRIM_PUT: begin
          seg_ticks = 28;
          if (t < 24) begin
            if (t % 3 == 0) p_sda = tx_byte[7 - t / 3];
            else p_scl = (t % 3 == 1);
          end else if (t == 24) begin
            p_sda = 1'b1;
          end else if (t == 25) begin
            p_scl = 1'b1;
            take = 1'b1;
          end else if (t == 26) begin
            p_scl = 1'b0;
          end else begin
            p_sda = 1'b0;
          end
        end
        default: begin
          seg_ticks = 22;
          if (t == 0) p_scl = 1'b0;
          else if (t == 1) p_sda = 1'b1;
          else if (t < 18) begin
            p_scl = (t % 2 == 0);
            take = (t % 2 == 0);
          end else if (t == 18) p_sda = (p_left > 1) ? 1'b0 : 1'b1;
          else if (t == 19) p_scl = 1'b1;
          else if (t == 20) p_scl = 0;
          else p_sda = 1'b0;
        end
      endcase
      if (take) begin
        if (prim == PRIM_PUT) p_ack = !tk.sda;
        else p_shift = {p_shift[6:0], tk.sda};
      end
      // Move to the next primitive at the end of this one
      if (t + 1 < seg_ticks) begin
        p_tick = t + 1;
      end else begin
        p_tick = 0;
        nxt = seq_step_t'(p_step + 1);
        case (p_step)
          SQ_P_STOP2: begin
            res.done_res = 1'b1;
            res.status = p_ack ? ST_OK : ST_NOACK;
            nxt = SQ_IDLE;
          end
          SQ_R_ADDRW, SQ_W_ADDR: if (!p_ack) nxt = SQ_F_STOP;
          SQ_R_ADDRR: if (p_left == 0) nxt = SQ_R_STOP2;
          SQ_R_GET: begin
            res.read_byte = p_shift;
            res.read_valid = 1'b1;
            res.read_last = (p_left == 1);
            p_left = p_left - 1'b1;
            p_shift = '0;
            nxt = (p_left == 0) ? SQ_R_STOP2 : SQ_R_GET;
          end
          SQ_R_STOP2: begin
            res.done_res = 1'b1;
            res.status = ST_OK;
            nxt = SQ_IDLE;
          end
          SQ_W_PSTOP: begin
            if (p_ack) begin
              res.done_res = 1'b1;
              res.status = ST_OK;
              nxt = SQ_IDLE;
            end else begin
              nxt = SQ_W_PSTART;
            end
          end
          SQ_F_STOP: begin
            res.done_res = 1'b1;
            res.status = ST_NOACK;
            nxt = SQ_IDLE;
          end
          default: ;
        endcase
        p_step = nxt;
      end
    end
    res.scl_drive = p_scl;
    res.sda_drive = p_sda;
    res.busy_res = (p_step != SQ_IDLE);
    return res;
  endfunction

  function automatic string fmt_levels(out_item_t r);
    return $sformatf("scl=%b sda=%b byte=%02h rv=%b rl=%b done=%b st=%0d busy=%b",
                     r.scl_drive, r.sda_drive, r.read_byte, r.read_valid, r.read_last,
                     r.done_res, r.status, r.busy_res);
  endfunction

  // Plain tick; SDA is low with the given percentage, noise adds stray requests
  function automatic bus_tick_t mk_tick(int zero_pct, bit noisy);
    bus_tick_t tk;
    tk.req = REQ_TICK;
    tk.offset = 13'($urandom_range(8191));
    tk.wbyte = 8'($urandom_range(255));
    tk.count = 14'($urandom_range(16383));
    tk.sda = ($urandom_range(99) < zero_pct) ? 1'b0 : 1'b1;
    if (noisy && $urandom_range(23) == 0) begin
      tk.req = req_t'($urandom_range(1, 3));
      tk.count = $urandom_range(1) ? 14'($urandom_range(2)) : 14'($urandom_range(8193, 16383));
    end
    return tk;
  endfunction

  // Queue one command and enough ticks to carry it through
  task automatic issue(req_t rq, int off, int wb, int cnt, int a_pct, int a_end,
                       int b_pct, int b_end, bit noisy);
    bus_tick_t tk;
    int        span;
    int        est;
    int        pct;
    span = (rq == REQ_READ) ? cnt : (rq == REQ_WRITE) ? 1 : 0;
    case (rq)
      REQ_PROBE: est = 40;
      REQ_READ:  est = 130 + 22 * cnt;
      default:   est = 200;
    endcase
    if (b_end + 80 > est) est = b_end + 80;
    if (rq != REQ_PROBE && off + span > EEPROM_BYTES_DEF) est = 2;
    tk = mk_tick(a_pct, 1'b0);
    tk.req = rq;
    tk.offset = 13'(off);
    tk.wbyte = 8'(wb);
    tk.count = 14'(cnt);
    tick_backlog.push_back(tk);
    for (int i = 1; i < est; i++) begin
      pct = (i < a_end) ? a_pct : (i < b_end) ? b_pct : 75;
      tick_backlog.push_back(mk_tick(pct, noisy));
    end
    n_cmds++;
    n_queued += est;
  endtask

  // Hold off new stimulus until every result is in and the master is idle
  task automatic settle();
    forever begin
      @(negedge clk);
      while (tick_backlog.size() != 0 || in_tvalid || bus_levels_q.size() != 0)
        @(negedge clk);
      if (p_step == SQ_IDLE) break;
      repeat (40) tick_backlog.push_back(mk_tick(75, 1'b0));
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_dev(logic [6:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: offer ticks in bursts, predict each accepted transaction
  always @(posedge clk) begin : drive_proc
    logic offer;
    if (!rst_n) begin
      p_dev = DEV_ADDR_RST;
      p_step = SQ_IDLE;
      p_shift = '0;
      p_left = '0;
      p_addr = '0;
      p_data = '0;
      p_scl = 1'b1;
      p_sda = 1'b1;
      p_tick = 0;
      p_ack = 1'b0;
      in_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) p_dev = cfg_wr_data;
      if (in_tvalid && in_tready) bus_levels_q.push_back(step_master(drv_tick));
      if (!in_tvalid || in_tready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_backlog.size() > 0) begin
          drv_tick = tick_backlog.pop_front();
          offer = 1'b1;
          in_tdata <= {4'b0000, drv_tick.sda, drv_tick.count, drv_tick.wbyte, drv_tick.offset};
          in_tuser <= drv_tick.req;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(10, 30);
              default:    gap_left = $urandom_range(1, 5);
            endcase
          end
        end
        in_tvalid <= offer;
      end
    end
  end

  // Long receiver hold-off, counted here on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_left <= 300;
      hold_served <= hold_served + 1;
    end
  end

  // Receiver: stall on a rotating pattern that changes now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(3))
          0: rdy_pat = '1;
          1: rdy_pat = $urandom;
          2: rdy_pat = $urandom | $urandom;
          default: rdy_pat = ($urandom & $urandom) | 32'h1;
        endcase
        pat_age = $urandom_range(50, 250);
      end else begin
        pat_age--;
      end
      rdy_pat = {rdy_pat[0], rdy_pat[31:1]};
      out_tready <= (hold_left == 0) && rdy_pat[0];
    end
  end

  // Monitor: sample the handshake mid-cycle, check against the oldest prediction
  always @(negedge clk) begin : check_proc
    out_item_t want;
    out_item_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl_drive = out_tdata[0];
      got.sda_drive = out_tdata[1];
      got.read_byte = out_tdata[9:2];
      got.read_valid = out_tuser[0];
      got.read_last = out_tlast;
      got.done_res = out_tdata[10];
      got.status = status_t'(out_tdata[12:11]);
      got.busy_res = out_tdata[13];
      if (bus_levels_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result: %s", fmt_levels(got));
      end else begin
        want = bus_levels_q.pop_front();
        n_checked++;
        if (want.read_valid) n_bytes++;
        if (want.done_res) begin
          case (want.status)
            ST_OK:    n_ok++;
            ST_NOACK: n_noack++;
            default:  n_range++;
          endcase
        end
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch at tick %0d: expected %s, got %s", n_checked,
                     fmt_levels(want), fmt_levels(got));
        end
      end
    end
  end

  // Stimulus: directed commands, then random phases under several device addresses
  initial begin : stim_proc
    int goal;
    int sel;
    int off;
    int cnt;
    int pct;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle ticks keep the lines released
    tick_backlog.push_back(mk_tick(0, 1'b0));
    tick_backlog.push_back(mk_tick(100, 1'b0));
    tick_backlog.push_back(mk_tick(0, 1'b0));
    tick_backlog.push_back(mk_tick(100, 1'b0));
    settle();
    // Probe found and not found
    issue(REQ_PROBE, 0, 0, 0, 100, 45, 0, 0, 1'b0);
    settle();
    issue(REQ_PROBE, 8191, 255, 16383, 0, 45, 0, 0, 1'b0);
    settle();
    // Zero-length read and the last byte of the array
    issue(REQ_READ, 0, 0, 0, 100, 30, 0, 0, 1'b0);
    settle();
    issue(REQ_READ, 8191, 8'ha5, 1, 100, 30, 0, 0, 1'b0);
    settle();
    // Range errors
    issue(REQ_READ, 8191, 0, 2, 75, 0, 0, 0, 1'b0);
    issue(REQ_READ, 1, 0, 8192, 75, 0, 0, 0, 1'b0);
    issue(REQ_READ, 0, 0, 16383, 75, 0, 0, 0, 1'b0);
    settle();
    // Write to the top address while the device stays busy for a while
    issue(REQ_WRITE, 8191, 255, 0, 100, 30, 0, 250, 1'b0);
    settle();
    // No acknowledge on the address byte
    issue(REQ_WRITE, 0, 0, 0, 0, 30, 0, 0, 1'b0);
    settle();
    issue(REQ_READ, 4660, 0, 3, 0, 30, 0, 0, 1'b0);
    settle();
    // Requests arriving while busy
    issue(REQ_READ, 2000, 8'h5a, 4, 100, 30, 0, 0, 1'b1);
    settle();
    issue(REQ_WRITE, 5461, 8'h3c, 5, 100, 30, 0, 0, 1'b1);
    settle();

    // Random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_dev(7'd0);
        1: write_dev(7'd127);
        2: write_dev(7'($urandom_range(127)));
        default: write_dev(DEV_ADDR_RST);
      endcase
      if (ph == 1) hold_asks++;
      goal = n_queued + 25;
      while (n_queued < goal) begin
        sel = $urandom_range(99);
        off = $urandom_range(8191);
        if ($urandom_range(9) == 0) off = $urandom_range(8180, 8191);
        case ($urandom_range(3))
          0: pct = 100;
          1: pct = 90;
          2: pct = 75;
          default: pct = 20;
        endcase
        if (sel < 30) begin
          issue(REQ_PROBE, off, $urandom_range(255), $urandom_range(16383), pct, 40, 0, 0,
                1'b1);
        end else if (sel < 62) begin
          cnt = ($urandom_range(4) == 0) ? $urandom_range(4, 10) : $urandom_range(3);
          issue(REQ_READ, off, $urandom_range(255), cnt, pct, 30, 0, 0, 1'b1);
        end else if (sel < 94) begin
          if ($urandom_range(3) == 0)
            issue(REQ_WRITE, off, $urandom_range(255), $urandom_range(16383), 100, 30, 0,
                  30 + $urandom_range(60, 160), 1'b1);
          else
            issue(REQ_WRITE, off, $urandom_range(255), $urandom_range(16383), pct, 30, 0, 0,
                  1'b1);
        end else begin
          issue(REQ_READ, off, $urandom_range(255), $urandom_range(8193, 16383), 75, 0, 0, 0,
                1'b1);
        end
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d bus ticks over %0d queued commands, four device addresses,",
             n_checked, n_cmds);
    $display("%0d bytes read, completions ok %0d / no-ack %0d / range %0d, %0d mismatches",
             n_bytes, n_ok, n_noack, n_range, n_bad);
    if (n_bad == 0 && bus_levels_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", bus_levels_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/iem_pkg.sv
rtl/iem_front.sv
rtl/iem_queue.sv
rtl/iem_back.sv
rtl/i2c_eeprom_master_unit.sv
bench/tb_i2c_eeprom_master_unit.sv
